>>> sv/sample_gap_linear_fill_defines.svh
// ----------------------------------------------------------------------------
// sample_gap_linear_fill_defines
// Assertion macros for the gap filler RTL, used by sgf_back.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_GAP_LINEAR_FILL_DEFINES_SVH
`define SAMPLE_GAP_LINEAR_FILL_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define SGF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define SGF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sgf_pkg.sv
// ----------------------------------------------------------------------------
// sgf_pkg
// Types and constants of the sample gap filler.
// ----------------------------------------------------------------------------
package sgf_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int SGF_MAX_FILL    = 63;
    localparam int SGF_INDEX_BITS  = 16;
    // index bits that survive masking; the port itself is SAMPLE_W wide
    localparam int SGF_IDX_W       = (SGF_INDEX_BITS < SAMPLE_W) ? SGF_INDEX_BITS : SAMPLE_W;
    // largest gap that is filled is SGF_MAX_FILL + 1
    localparam int SGF_GAP_W       = $clog2(SGF_MAX_FILL + 2);
    localparam int SGF_DIV_STEPS   = SAMPLE_W;
    localparam int SGF_DIV_CNT_W   = $clog2(SGF_DIV_STEPS + 1);
    // power of two
    localparam int SGF_QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_PASS,
        CMD_FILL,
        CMD_ERR
    } sgf_kind_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_FILL,
        B_LAST
    } sgf_back_state_t;

    typedef struct packed {
        sgf_kind_t                   kind;
        logic [SAMPLE_W-1:0]         index;
        logic signed [SAMPLE_W-1:0]  value;
        logic [SAMPLE_W-1:0]         prev_index;
        logic signed [SAMPLE_W-1:0]  prev_value;
        logic signed [SAMPLE_W:0]    diff;
        logic [SGF_GAP_W-1:0]        gap;
    } sgf_cmd_t;

endpackage

>>> sv/sgf_front.sv
// ----------------------------------------------------------------------------
// sgf_front
// Accepts samples, drops repeats, classifies each kept sample as pass,
// fill or gap error and keeps the last kept sample.
// ----------------------------------------------------------------------------
module sgf_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sgf_pkg::SAMPLE_W-1:0]        sample_index,
    input  logic signed [sgf_pkg::SAMPLE_W-1:0] sample_value,
    input  logic                                q_full,
    output logic                                q_push,
    output sgf_pkg::sgf_cmd_t                   q_cmd
);
    import sgf_pkg::*;

    logic                       have_prev_reg, have_prev_next;
    logic [SAMPLE_W-1:0]        prev_idx_reg, prev_idx_next;
    logic signed [SAMPLE_W-1:0] prev_val_reg, prev_val_next;

    logic [SAMPLE_W-1:0]        idx;
    logic [SAMPLE_W:0]          prev_plus1;
    logic [SAMPLE_W-1:0]        missing;
    logic signed [SAMPLE_W:0]   diff;
    logic                       accept, dup, jump, too_far;

    assign idx        = SAMPLE_W'(sample_index[SGF_IDX_W-1:0]);
    assign prev_plus1 = {1'b0, prev_idx_reg} + (SAMPLE_W+1)'(1);
    assign jump       = have_prev_reg && ({1'b0, idx} > prev_plus1);
    assign missing    = idx - prev_idx_reg - SAMPLE_W'(1);
    assign too_far    = missing > SAMPLE_W'(SGF_MAX_FILL);
    assign diff       = (SAMPLE_W+1)'(sample_value) - (SAMPLE_W+1)'(prev_val_reg);

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign dup      = have_prev_reg && (idx == prev_idx_reg);
    assign q_push   = accept && !dup;

    always_comb
    begin
        q_cmd.index      = idx;
        q_cmd.value      = sample_value;
        q_cmd.prev_index = prev_idx_reg;
        q_cmd.prev_value = prev_val_reg;
        q_cmd.diff       = diff;
        q_cmd.gap        = SGF_GAP_W'(idx - prev_idx_reg);
        priority if (!jump)
        begin
            q_cmd.kind = CMD_PASS;
        end
        else if (too_far)
        begin
            q_cmd.kind = CMD_ERR;
        end
        else
        begin
            q_cmd.kind = CMD_FILL;
        end
    end

    always_comb
    begin
        have_prev_next = have_prev_reg;
        prev_idx_next  = prev_idx_reg;
        prev_val_next  = prev_val_reg;
        if (q_push)
        begin
            have_prev_next = 1'b1;
            prev_idx_next  = idx;
            prev_val_next  = sample_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_idx_reg  <= '0;
            prev_val_reg  <= '0;
        end
        else
        begin
            have_prev_reg <= have_prev_next;
            prev_idx_reg  <= prev_idx_next;
            prev_val_reg  <= prev_val_next;
        end
    end

endmodule

>>> sv/sgf_queue.sv
// ----------------------------------------------------------------------------
// sgf_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module sgf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sgf_pkg::sgf_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output sgf_pkg::sgf_cmd_t head_cmd
);
    import sgf_pkg::*;

    localparam int DEPTH = SGF_QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sgf_cmd_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> sv/sgf_back.sv
// ----------------------------------------------------------------------------
// sgf_back
// Runs one command: for a fill, serial divide for the step and one beat per
// fill; then the original sample, through a registered output.
// ----------------------------------------------------------------------------
module sgf_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_empty,
    output logic                                 q_pop,
    input  sgf_pkg::sgf_cmd_t                    q_cmd,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sgf_pkg::SAMPLE_W-1:0]         out_index,
    output logic signed [sgf_pkg::SAMPLE_W-1:0]  out_value,
    output logic                                 is_filled,
    output logic                                 gap_error,
    output logic                                 last_of_run
);
    import sgf_pkg::*;

`include "sample_gap_linear_fill_defines.svh"

    sgf_back_state_t            state_reg, state_next;
    sgf_cmd_t                   cmd_reg, cmd_next;
    logic [SGF_DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [SGF_GAP_W-1:0]       rem_reg, rem_next;
    logic [SAMPLE_W-1:0]        quo_reg, quo_next;
    logic signed [SAMPLE_W:0]   step_reg, step_next;
    logic signed [SAMPLE_W:0]   acc_reg, acc_next;
    logic [SAMPLE_W-1:0]        fill_idx_reg, fill_idx_next;
    logic [SGF_GAP_W-1:0]       fill_cnt_reg, fill_cnt_next;

    logic                       out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]        out_index_reg, out_index_next;
    logic signed [SAMPLE_W-1:0] out_value_reg, out_value_next;
    logic                       is_filled_reg, is_filled_next;
    logic                       gap_error_reg, gap_error_next;
    logic                       last_reg, last_next;

    logic                       emit_ok;
    logic signed [SAMPLE_W:0]   mag;
    logic [SGF_GAP_W:0]         shifted;
    logic [SGF_GAP_W+1:0]       trial;
    logic                       borrow;
    logic [SAMPLE_W-1:0]        quo_step;
    logic signed [SAMPLE_W:0]   quo_ext;

    assign emit_ok = !out_valid_reg || out_ready;
    assign mag     = q_cmd.diff[SAMPLE_W] ? -q_cmd.diff : q_cmd.diff;

    // one restoring step: remainder stays below gap
    assign shifted  = {rem_reg, quo_reg[SAMPLE_W-1]};
    assign trial    = {1'b0, shifted} - {2'b00, cmd_reg.gap};
    assign borrow   = trial[SGF_GAP_W+1];
    assign quo_step = {quo_reg[SAMPLE_W-2:0], !borrow};
    assign quo_ext  = $signed({1'b0, quo_step});

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        div_cnt_next   = div_cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        fill_idx_next  = fill_idx_reg;
        fill_cnt_next  = fill_cnt_reg;
        q_pop          = 1'b0;

        out_valid_next = out_valid_reg && !out_ready;
        out_index_next = out_index_reg;
        out_value_next = out_value_reg;
        is_filled_next = is_filled_reg;
        gap_error_next = gap_error_reg;
        last_next      = last_reg;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    cmd_next     = q_cmd;
                    rem_next     = '0;
                    quo_next     = mag[SAMPLE_W-1:0];
                    div_cnt_next = SGF_DIV_CNT_W'(SGF_DIV_STEPS);
                    state_next   = (q_cmd.kind == CMD_FILL) ? B_DIV : B_LAST;
                end
            end
            B_DIV:
            begin
                rem_next     = borrow ? shifted[SGF_GAP_W-1:0] : trial[SGF_GAP_W-1:0];
                quo_next     = quo_step;
                div_cnt_next = div_cnt_reg - SGF_DIV_CNT_W'(1);
                if (div_cnt_reg == SGF_DIV_CNT_W'(1))
                begin
                    // quotient truncates toward zero: sign goes on the magnitude
                    step_next     = cmd_reg.diff[SAMPLE_W] ? -quo_ext : quo_ext;
                    acc_next      = (SAMPLE_W+1)'(cmd_reg.prev_value) + step_next;
                    fill_idx_next = cmd_reg.prev_index + SAMPLE_W'(1);
                    fill_cnt_next = cmd_reg.gap - SGF_GAP_W'(1);
                    state_next    = B_FILL;
                end
            end
            B_FILL:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = fill_idx_reg;
                    out_value_next = acc_reg[SAMPLE_W-1:0];
                    is_filled_next = 1'b1;
                    gap_error_next = 1'b0;
                    last_next      = 1'b0;
                    acc_next       = acc_reg + step_reg;
                    fill_idx_next  = fill_idx_reg + SAMPLE_W'(1);
                    fill_cnt_next  = fill_cnt_reg - SGF_GAP_W'(1);
                    if (fill_cnt_reg == SGF_GAP_W'(1))
                    begin
                        state_next = B_LAST;
                    end
                end
            end
            B_LAST:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = cmd_reg.index;
                    out_value_next = cmd_reg.value;
                    is_filled_next = 1'b0;
                    gap_error_next = (cmd_reg.kind == CMD_ERR);
                    last_next      = 1'b1;
                    state_next     = B_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        div_cnt_reg   <= div_cnt_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        step_reg      <= step_next;
        acc_reg       <= acc_next;
        fill_idx_reg  <= fill_idx_next;
        fill_cnt_reg  <= fill_cnt_next;
        out_index_reg <= out_index_next;
        out_value_reg <= out_value_next;
        is_filled_reg <= is_filled_next;
        gap_error_reg <= gap_error_next;
        last_reg      <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_index   = out_index_reg;
    assign out_value   = out_value_reg;
    assign is_filled   = is_filled_reg;
    assign gap_error   = gap_error_reg;
    assign last_of_run = last_reg;

    `SGF_ASSERT_NEXT(a_div_to_fill, (state_reg == B_DIV) && (div_cnt_reg == SGF_DIV_CNT_W'(1)),
        state_reg == B_FILL, "divide did not end in fill")
    `SGF_ASSERT_NOW(a_fill_kind, state_reg == B_FILL,
        (cmd_reg.kind == CMD_FILL) && (fill_cnt_reg != '0), "fill without fill command")
    `SGF_ASSERT_NOW(a_fill_below, state_reg == B_FILL,
        fill_idx_reg < cmd_reg.index, "fill index reached sample index")

endmodule

>>> sv/sample_gap_linear_fill.sv
// ----------------------------------------------------------------------------
// sample_gap_linear_fill: linear-interpolation gap filler for (index, value) beats
// Pass or gap-error sample: one output beat, through the queue, command and output registers.
// Repeated index: taken at the input and dropped, no output beat.
// G missing indices: serial step divide, G fill beats, then the sample;
// the next command is taken only after the sample beat; 2-deep queue.
// rst_n is asynchronous, active low; it clears the kept sample, queue and output valid.
// ----------------------------------------------------------------------------
module sample_gap_linear_fill (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sgf_pkg::SAMPLE_W-1:0]        sample_index,
    input  logic signed [sgf_pkg::SAMPLE_W-1:0] sample_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sgf_pkg::SAMPLE_W-1:0]        out_index,
    output logic signed [sgf_pkg::SAMPLE_W-1:0] out_value,
    output logic                                is_filled,
    output logic                                gap_error,
    output logic                                last_of_run
);
    import sgf_pkg::*;

    logic     q_push, q_full, q_pop, q_empty;
    sgf_cmd_t push_cmd, head_cmd;

    sgf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_index (sample_index),
        .sample_value (sample_value),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd)
    );

    sgf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_cmd (head_cmd)
    );

    sgf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_cmd       (head_cmd),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_index   (out_index),
        .out_value   (out_value),
        .is_filled   (is_filled),
        .gap_error   (gap_error),
        .last_of_run (last_of_run)
    );

endmodule

>>> tb/sv/tb_sample_gap_linear_fill.sv
// ----------------------------------------------------------------------------
// tb_sample_gap_linear_fill
// Self-checking bench for the gap filler: directed and random sample streams
// go in, every output beat is checked in order against a behavioral model of
// the fill, with random sender bursts, receiver stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb_sample_gap_linear_fill;

    import sgf_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 8;
    localparam int TIMEOUT_CYCLES = 600000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_REPORTS    = 10;
    localparam logic [SAMPLE_W-1:0] IDX_MASK = SAMPLE_W'((64'd1 << SGF_IDX_W) - 1);

    typedef enum logic [1:0] {
        RX_FULL,
        RX_BUSY,
        RX_SLOW
    } rx_mode_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]        idx;
        logic signed [SAMPLE_W-1:0] val;
        logic                       filled;
        logic                       err;
        logic                       last;
    } fill_beat_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [SAMPLE_W-1:0]         sample_index = '0;
    logic signed [SAMPLE_W-1:0]  sample_value = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [SAMPLE_W-1:0]         out_index;
    logic signed [SAMPLE_W-1:0]  out_value;
    logic                        is_filled;
    logic                        gap_error;
    logic                        last_of_run;

    // kept sample of the model
    bit                          kept_valid = 1'b0;
    logic [SAMPLE_W-1:0]         kept_index = '0;
    logic signed [SAMPLE_W-1:0]  kept_value = '0;

    fill_beat_t                  pending_beats[$];
    int                          mismatch_count = 0;

    // sender pacing
    bit                          tx_busy = 1'b0;
    bit                          gaps_on = 1'b1;
    int                          burst_left = 0;

    // receiver pacing
    rx_mode_t                    rx_mode = RX_FULL;
    int                          hold_token = 0;
    int                          hold_seen = 0;
    int                          hold_left = 0;
    logic [7:0]                  rx_pattern = 8'hFF;
    int                          rx_phase = 0;

    sample_gap_linear_fill dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_index (sample_index),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_index    (out_index),
        .out_value    (out_value),
        .is_filled    (is_filled),
        .gap_error    (gap_error),
        .last_of_run  (last_of_run)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("timeout: %0d beats still pending", pending_beats.size());
        $display("TEST FAILED");
        $finish;
    end

    // Expected beats for one accepted sample: fills first, then the sample; a repeated index gives none.
    task automatic predict_fill(input logic [SAMPLE_W-1:0] raw_index,
                                input logic signed [SAMPLE_W-1:0] raw_value);
        logic [SAMPLE_W-1:0] idx;
        int                  gap;
        int                  step;
        logic                too_wide;
        fill_beat_t          beat;
        idx = raw_index & IDX_MASK;
        too_wide = 1'b0;
        if (kept_valid && idx == kept_index)
            return;
        if (kept_valid && int'(idx) > int'(kept_index) + 1)
        begin
            gap = int'(idx) - int'(kept_index);
            if (gap - 1 > SGF_MAX_FILL)
                too_wide = 1'b1;
            else
            begin
                // SV integer divide truncates toward zero
                step = (int'(raw_value) - int'(kept_value)) / gap;
                for (int i = 1; i < gap; i++)
                begin
                    beat.idx    = kept_index + SAMPLE_W'(i);
                    beat.val    = SAMPLE_W'(int'(kept_value) + step * i);
                    beat.filled = 1'b1;
                    beat.err    = 1'b0;
                    beat.last   = 1'b0;
                    pending_beats.push_back(beat);
                end
            end
        end
        beat.idx    = idx;
        beat.val    = raw_value;
        beat.filled = 1'b0;
        beat.err    = too_wide;
        beat.last   = 1'b1;
        pending_beats.push_back(beat);
        kept_valid = 1'b1;
        kept_index = idx;
        kept_value = raw_value;
    endtask

    function automatic void note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, what);
    endfunction

    always @(posedge clk)
    begin
        fill_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_beats.size() == 0)
                note_mismatch($sformatf(
                    {"unexpected beat idx=%0d val=%0d ",
                     "fill=%0b err=%0b last=%0b"},
                    out_index, out_value, is_filled, gap_error, last_of_run));
            else
            begin
                want = pending_beats.pop_front();
                if (out_index !== want.idx || out_value !== want.val ||
                    is_filled !== want.filled || gap_error !== want.err ||
                    last_of_run !== want.last)
                    note_mismatch($sformatf(
                        {"exp idx=%0d val=%0d fill=%0b err=%0b last=%0b, ",
                         "got idx=%0d val=%0d fill=%0b err=%0b last=%0b"},
                        want.idx, want.val, want.filled, want.err, want.last,
                        out_index, out_value, is_filled, gap_error, last_of_run));
            end
        end
    end

    // Receiver: per-mode stall pattern, plus a counted hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_FULL: out_ready <= 1'b1;
                RX_BUSY: out_ready <= ($urandom_range(0, 2) != 0);
                default:
                begin
                    if (rx_phase == 0)
                        rx_pattern = 8'($urandom);
                    out_ready <= rx_pattern[rx_phase];
                    rx_phase = (rx_phase + 1) % 8;
                end
            endcase
        end
    end

    task automatic idle_sender();
        if (tx_busy)
        begin
            in_valid <= 1'b0;
            tx_busy = 1'b0;
        end
    endtask

    // Drives one beat and holds it until accepted; valid stays up for a
    // back-to-back beat and drops only when a gap follows.
    task automatic send_sample(input logic [SAMPLE_W-1:0] idx,
                               input logic signed [SAMPLE_W-1:0] val);
        in_valid     <= 1'b1;
        sample_index <= idx;
        sample_value <= val;
        tx_busy = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_fill(idx, val);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                idle_sender();
                repeat ($urandom_range(1, 7)) @(posedge clk);
                burst_left = $urandom_range(1, 10);
            end
            else
                burst_left--;
        end
    endtask

    task automatic wait_drain();
        idle_sender();
        while (pending_beats.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_index();
        int r;
        int step;
        r = $urandom_range(0, 99);
        if (!kept_valid || r >= 90)
            return SAMPLE_W'($urandom_range(0, 65535));
        if (r < 8)
            return kept_index;
        if (r < 20)
            step = 1;
        else if (r < 70)
            step = $urandom_range(2, 65);
        else if (r < 78)
            step = $urandom_range(66, 3000);
        else
            return SAMPLE_W'($urandom_range(0, int'(kept_index)));
        return kept_index + SAMPLE_W'(step);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_value();
        if ($urandom_range(0, 1) == 0)
            return SAMPLE_W'($urandom_range(0, 65535));
        return kept_value + SAMPLE_W'($urandom_range(0, 400)) - SAMPLE_W'(200);
    endfunction

    task automatic test_first_and_repeat();
        send_sample(16'd10, 16'sd1000);
        send_sample(16'd10, 16'sd7);
        send_sample(16'd10, -16'sd1);
        send_sample(16'd11, -16'sd32768);
    endtask

    task automatic test_fill_values();
        send_sample(16'd15, 16'sd32767);        // full positive swing
        send_sample(16'd20, -16'sd32768);       // full negative swing
        send_sample(16'd23, -16'sd32768);       // flat gap
        send_sample(16'd30, -16'sd1);
        send_sample(16'd33, -16'sd8);           // negative step truncates toward zero
    endtask

    task automatic test_gap_bound();
        send_sample(16'd3, 16'sd0);             // step backward
        send_sample(16'd67, 16'sd500);          // widest fillable gap
        send_sample(16'd132, -16'sd1);          // one past the bound
        send_sample(16'd132, 16'sd5);
        send_sample(16'd134, 16'sd9);
        send_sample(16'd200, 16'sd0);
    endtask

    task automatic test_index_extremes();
        send_sample(16'd65535, 16'sd1);
        send_sample(16'd0, 16'sd0);
        send_sample(16'd1, 16'sd0);
        send_sample(16'd65535, -16'sd100);
        send_sample(16'd65533, 16'sd100);
        send_sample(16'd65535, -16'sd100);
        send_sample(16'd65535, 16'sd3);
        send_sample(16'd0, 16'sd32767);
        send_sample(16'd64, -16'sd32768);
    endtask

    task automatic test_random_stream(input int count, input rx_mode_t mode, input bit gaps);
        logic [SAMPLE_W-1:0]        idx;
        logic signed [SAMPLE_W-1:0] val;
        rx_mode = mode;
        gaps_on = gaps;
        for (int n = 0; n < count; n++)
        begin
            idx = pick_index();
            val = pick_value();
            send_sample(idx, val);
        end
    endtask

    // Receiver holds off while the sender keeps offering back to back.
    task automatic test_backpressure();
        rx_mode = RX_FULL;
        gaps_on = 1'b0;
        hold_token++;
        for (int n = 0; n < 16; n++)
            send_sample(kept_index + SAMPLE_W'($urandom_range(1, 6)), pick_value());
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rx_mode = RX_BUSY;
        gaps_on = 1'b1;
        test_first_and_repeat();
        test_fill_values();
        test_gap_bound();
        test_index_extremes();
        wait_drain();

        test_random_stream(45, RX_BUSY, 1'b1);
        test_random_stream(45, RX_FULL, 1'b0);
        test_backpressure();
        test_random_stream(45, RX_SLOW, 1'b1);
        test_random_stream(45, RX_BUSY, 1'b0);

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_beats.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
